[hdl/x128p_pkg.sv]
// Shared types, codes and constants of the xorshift128+ generator.
package x128p_pkg;

  // Operation codes carried on the request channel.
  typedef enum logic [1:0] {
    FUNC_RESEED = 2'd0,
    FUNC_RAW    = 2'd1,
    FUNC_FRAC   = 2'd2,
    FUNC_INDEX  = 2'd3
  } func_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    FSM_BOOT,
    FSM_IDLE,
    FSM_MUL,
    FSM_DIV,
    FSM_DONE
  } fsm_t;

  // Splitmix64 constants.
  localparam logic [63:0] SM_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] SM_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] SM_MUL2   = 64'h94d049bb133111eb;

  // Seed loaded after reset.
  localparam logic [63:0] BOOT_SEED = 64'd1;

  // Shift that turns the raw sum into a 53-bit fraction numerator.
  localparam int unsigned FRAC_SHIFT = 11;

  // Field widths.
  localparam int unsigned WORD_W = 64;
  localparam int unsigned MOD_W  = 31;
  localparam int unsigned CNT_W  = 6;

endpackage

[hdl/x128p_req_if.sv]
// Request channel: operation code, seed and modulus under valid/ready.
interface x128p_req_if;
  logic                valid;
  logic                ready;
  x128p_pkg::func_t    func;
  logic [63:0]         seed_value;
  logic [30:0]         modulus;

  modport source (output valid, func, seed_value, modulus, input ready);
  modport sink   (input valid, func, seed_value, modulus, output ready);
endinterface

[hdl/x128p_rsp_if.sv]
// Response channel: result value and error flag under valid/ready.
interface x128p_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        bad_modulus;

  modport source (output valid, value, bad_modulus, input ready);
  modport sink   (input valid, value, bad_modulus, output ready);
endinterface

[hdl/xorshift128plus_generator.sv]
// xorshift128+ generator with splitmix64 seeding and a shared serial multiply/divide unit.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-----------------------------------
//   req     | in  | valid / ready | func, seed_value, modulus
//   rsp     | out | valid / ready | value, bad_modulus
//
// Raw and fraction requests pass from accept through the DONE state to rsp; a bounded index
// first runs one remainder step per cycle through a 32-bit compare and subtract, or skips
// that when the modulus is zero. A reseed runs four 64-bit multiplies by constants,
// one bit per cycle through a single 64-bit adder. After reset the block seeds itself
// with seed one with req.ready low. The next request is taken while a
// result still waits on rsp; a held result blocks only the completion of the next beat.
module xorshift128plus_generator (
  input logic             clk,
  input logic             rst,
  x128p_req_if.sink       req,
  x128p_rsp_if.source     rsp
);
  import x128p_pkg::*;

  // Control registers.
  fsm_t fsm, fsm_next;
  logic booting, booting_next;
  logic mul_second, mul_second_next;
  logic word_hi, word_hi_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic out_valid, out_valid_next;

  // Datapath registers.
  logic [MOD_W-1:0] modulus_q, modulus_q_next;
  logic [WORD_W-1:0] base, base_next;
  logic [WORD_W-1:0] mcand, mcand_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [WORD_W-1:0] dividend, dividend_next;
  logic [MOD_W-1:0] rem, rem_next;
  logic [WORD_W-1:0] state_lo, state_lo_next;
  logic [WORD_W-1:0] state_hi, state_hi_next;
  logic [WORD_W-1:0] res_value, res_value_next;
  logic res_bad, res_bad_next;
  logic [WORD_W-1:0] out_value, out_value_next;
  logic out_bad, out_bad_next;

  // Combinational helpers.
  logic [WORD_W-1:0] adv_b, adv_hi, adv_sum;
  logic [WORD_W-1:0] mul_sum, mix_a, base_inc;
  logic [MOD_W:0]    div_shift, div_diff;
  logic              mul_bit;

  assign req.ready       = (fsm == FSM_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.value       = out_value;
  assign rsp.bad_modulus = out_bad;

  // One xorshift128+ step from the current state words.
  always_comb begin
    adv_b   = state_hi ^ (state_hi << 23);
    adv_hi  = adv_b ^ state_lo ^ (adv_b >> 18) ^ (state_lo >> 5);
    adv_sum = adv_hi + state_lo;
  end

  // Shared serial units: one multiplier bit and one quotient bit per cycle.
  always_comb begin
    mul_bit   = mul_second ? SM_MUL2[cnt] : SM_MUL1[cnt];
    mul_sum   = acc + (mul_bit ? mcand : '0);
    mix_a     = mul_sum ^ (mul_sum >> 27);
    base_inc  = base + 64'd1;
    div_shift = {rem, dividend[WORD_W-1]};
    div_diff  = div_shift - {1'b0, modulus_q};
  end

  // Sequencer: next state and datapath updates.
  always_comb begin
    fsm_next        = fsm;
    booting_next    = booting;
    mul_second_next = mul_second;
    word_hi_next    = word_hi;
    cnt_next        = cnt;
    modulus_q_next  = modulus_q;
    base_next       = base;
    mcand_next      = mcand;
    acc_next        = acc;
    dividend_next   = dividend;
    rem_next        = rem;
    state_lo_next   = state_lo;
    state_hi_next   = state_hi;
    res_value_next  = res_value;
    res_bad_next    = res_bad;
    out_value_next  = out_value;
    out_bad_next    = out_bad;

    // The response register empties when its beat is taken.
    out_valid_next  = out_valid && !rsp.ready;

    unique case (fsm)
      FSM_BOOT: begin
        base_next       = BOOT_SEED + SM_GOLDEN;
        mcand_next      = (BOOT_SEED + SM_GOLDEN) ^ ((BOOT_SEED + SM_GOLDEN) >> 30);
        acc_next        = '0;
        cnt_next        = '0;
        mul_second_next = 1'b0;
        word_hi_next    = 1'b0;
        fsm_next        = FSM_MUL;
      end

      FSM_IDLE: begin
        if (req.valid) begin
          modulus_q_next = req.modulus;
          res_value_next = '0;
          res_bad_next   = 1'b0;
          if (req.func == FUNC_RESEED) begin
            base_next       = req.seed_value + SM_GOLDEN;
            mcand_next      = (req.seed_value + SM_GOLDEN)
                              ^ ((req.seed_value + SM_GOLDEN) >> 30);
            acc_next        = '0;
            cnt_next        = '0;
            mul_second_next = 1'b0;
            word_hi_next    = 1'b0;
            fsm_next        = FSM_MUL;
          end else begin
            state_lo_next = adv_b;
            state_hi_next = adv_hi;
            fsm_next      = FSM_DONE;
            case (req.func)
              FUNC_RAW:  res_value_next = adv_sum;
              FUNC_FRAC: res_value_next = adv_sum >> FRAC_SHIFT;
              default: begin
                if (req.modulus == '0) begin
                  res_bad_next = 1'b1;
                end else begin
                  dividend_next = adv_sum;
                  rem_next      = '0;
                  cnt_next      = '0;
                  fsm_next      = FSM_DIV;
                end
              end
            endcase
          end
        end
      end

      // Shift-add multiply by a splitmix64 constant.
      FSM_MUL: begin
        acc_next   = mul_sum;
        mcand_next = mcand << 1;
        cnt_next   = cnt + 1'b1;
        if (cnt == '1) begin
          acc_next = '0;
          cnt_next = '0;
          if (!mul_second) begin
            mcand_next      = mix_a;
            mul_second_next = 1'b1;
          end else begin
            mul_second_next = 1'b0;
            if (!word_hi) begin
              state_lo_next = mul_sum ^ (mul_sum >> 31);
              word_hi_next  = 1'b1;
              mcand_next    = base_inc ^ (base_inc >> 30);
            end else begin
              state_hi_next = mul_sum ^ (mul_sum >> 31);
              booting_next  = 1'b0;
              fsm_next      = booting ? FSM_IDLE : FSM_DONE;
            end
          end
        end
      end

      // Restoring division: one remainder bit per cycle.
      FSM_DIV: begin
        dividend_next = dividend << 1;
        cnt_next      = cnt + 1'b1;
        if (div_shift >= {1'b0, modulus_q}) begin
          rem_next = div_diff[MOD_W-1:0];
        end else begin
          rem_next = div_shift[MOD_W-1:0];
        end
        if (cnt == '1) begin
          res_value_next = {{(WORD_W-MOD_W){1'b0}}, rem_next};
          fsm_next       = FSM_DONE;
        end
      end

      // Hand the result to the response register once it is free.
      FSM_DONE: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_value_next = res_value;
          out_bad_next   = res_bad;
          fsm_next       = FSM_IDLE;
        end
      end

      default: fsm_next = FSM_IDLE;
    endcase
  end

  // Control state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm        <= FSM_BOOT;
      booting    <= 1'b1;
      mul_second <= 1'b0;
      word_hi    <= 1'b0;
      cnt        <= '0;
      out_valid  <= 1'b0;
    end else begin
      fsm        <= fsm_next;
      booting    <= booting_next;
      mul_second <= mul_second_next;
      word_hi    <= word_hi_next;
      cnt        <= cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    modulus_q <= modulus_q_next;
    base      <= base_next;
    mcand     <= mcand_next;
    acc       <= acc_next;
    dividend  <= dividend_next;
    rem       <= rem_next;
    state_lo  <= state_lo_next;
    state_hi  <= state_hi_next;
    res_value <= res_value_next;
    res_bad   <= res_bad_next;
    out_value <= out_value_next;
    out_bad   <= out_bad_next;
  end

endmodule
